// ===== design/kssh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kssh_pkg - shared types for the k-sorted stream sorter
// Payload structs, the link between neighbouring sort cells, cell operations
// and controller states.
// ----------------------------------------------------------------------------
package kssh_pkg;

   localparam int unsigned MAX_WINDOW_DEF = 16;
   localparam int unsigned DATA_W         = 32;
   localparam int unsigned BOUND_W        = 4;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_value;
      logic                     end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_result;
   } rsp_payload_type;

   // what a cell shows its neighbours
   typedef struct packed {
      logic                     valid;
      logic                     le;      // valid and value <= incoming sample
      logic signed [DATA_W-1:0] value;
   } cell_link_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP_INSERT,
      OP_SHIFT
   } cell_op_type;

   typedef enum logic {
      ST_STREAM,
      ST_FLUSH
   } state_type;

endpackage : kssh_pkg
`default_nettype wire

// ===== design/k_sorted_stream_heap_sorter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// k_sorted_stream_heap_sorter_top - sorter for streams displaced by at most K
// Keeps a window of K+1 values in a chain of sorted cells and releases the
// smallest once the window is full.
// ----------------------------------------------------------------------------
// Usage: program K through csr_wr_en/csr_wr_data while idle, then stream
// values in. The first K+1 transactions are only stored; each later one
// returns the current minimum in the cycle after acceptance. A transaction
// flagged end_of_stream is stored (after any pop) and then the whole window
// drains, the last value flagged final_result; no input is taken during the
// drain. Streaming takes one transaction and the drain one value per cycle
// while the result side keeps up, set by the single compare-and-select step
// in every cell; the drain releases every value held (up to K+1, at most
// MAX_WINDOW). Lowering K mid-stream keeps the fill level where it is.
// ----------------------------------------------------------------------------
module k_sorted_stream_heap_sorter_top #(
   parameter int unsigned MAX_WINDOW = kssh_pkg::MAX_WINDOW_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  kssh_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output kssh_pkg::rsp_payload_type            rsp_payload,
   input  wire                                  csr_wr_en,
   input  wire  [kssh_pkg::BOUND_W-1:0]         csr_wr_data
);
   import kssh_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int unsigned WIN_W = (CNT_W > BOUND_W + 1) ? CNT_W : BOUND_W + 1;

   // configuration
   logic [BOUND_W-1:0] bound_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= '0;
      end else if (csr_wr_en) begin
         bound_ff <= csr_wr_data;
      end
   end

   // control
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WIN_W-1:0]  window;
   logic [WIN_W-1:0]  bound_plus;
   logic              window_full;
   logic              out_free;
   logic              accept;
   logic              emit;
   logic              emit_final;
   cell_op_type       op;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   cell_link_type     link [MAX_WINDOW];

   assign bound_plus  = WIN_W'(bound_ff) + WIN_W'(1);
   assign window      = (bound_plus > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : bound_plus;
   assign window_full = WIN_W'(count_ff) >= window;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_STREAM: begin
            if (accept && req_payload.end_of_stream) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free && (count_ff == CNT_W'(1))) begin
               state_in = ST_STREAM;
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_ready  = 1'b0;
      op         = OP_HOLD;
      emit       = 1'b0;
      emit_final = 1'b0;
      count_in   = count_ff;
      case (state_ff)
         ST_STREAM: begin
            req_ready = out_free;
            if (accept) begin
               if (window_full) begin
                  op   = OP_POP_INSERT;
                  emit = 1'b1;
               end else begin
                  op       = OP_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               op         = OP_SHIFT;
               emit       = 1'b1;
               emit_final = (count_ff == CNT_W'(1));
               count_in   = count_ff - CNT_W'(1);
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // output register; the head of the chain is always the value released
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = link[0].value;
         rsp_data_in.final_result = emit_final;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // cell chain
   localparam cell_link_type LEFT_EDGE  = '{valid: 1'b1, le: 1'b1, value: '0};
   localparam cell_link_type RIGHT_EDGE = '{valid: 1'b0, le: 1'b0, value: '0};

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      if (i == 0) begin : g_head
         assign left_link = LEFT_EDGE;
      end else begin : g_body
         assign left_link = link[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign right_link = RIGHT_EDGE;
      end else begin : g_inner
         assign right_link = link[i+1];
      end

      kssh_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op_i     (op),
         .head_i   (i == 0),
         .sample_i (req_payload.sample_value),
         .left_i   (left_link),
         .right_i  (right_link),
         .self_o   (link[i])
      );

      if (i < MAX_WINDOW - 1) begin : g_chk
         // chain stays ascending and filled from the head
         a_sorted: assert property (@(posedge clock) disable iff (reset)
            link[i+1].valid |-> (link[i].valid &&
                                 ($signed(link[i].value) <= $signed(link[i+1].value))))
            else $error("cell chain out of order");
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WINDOW))
      else $error("fill level beyond window storage");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (count_ff != '0))
      else $error("drain with empty window");

   a_final_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.final_result) |-> (count_ff == '0))
      else $error("final value released with values left");

endmodule : k_sorted_stream_heap_sorter_top
`default_nettype wire

// ===== design/kssh_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kssh_cell - one slot of the sorted cell chain
// Holds one value of the window. The chain is kept in ascending order from
// the head; each cell picks its next value from itself, a neighbour or the
// broadcast sample.
// ----------------------------------------------------------------------------
module kssh_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  kssh_pkg::cell_op_type        op_i,
   input  wire                          head_i,
   input  wire signed [kssh_pkg::DATA_W-1:0] sample_i,
   input  kssh_pkg::cell_link_type      left_i,
   input  kssh_pkg::cell_link_type      right_i,
   output kssh_pkg::cell_link_type      self_o
);
   import kssh_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     le_self;
   logic                     gt_self;
   logic                     gt_left;

   assign le_self = valid_ff && ($signed(value_ff) <= $signed(sample_i));
   assign gt_self = valid_ff && !le_self;
   assign gt_left = left_i.valid && !left_i.le;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (op_i)
         OP_INSERT: begin
            // sample slots in after the last entry not above it
            valid_in = left_i.valid;
            if (le_self) begin
               value_in = value_ff;
            end else if (gt_left) begin
               value_in = left_i.value;
            end else begin
               value_in = sample_i;
            end
         end
         OP_POP_INSERT: begin
            // head leaves, chain moves towards the head, sample slots in
            if (right_i.le) begin
               value_in = right_i.value;
            end else if (!head_i && gt_self) begin
               value_in = value_ff;
            end else begin
               value_in = sample_i;
            end
         end
         OP_SHIFT: begin
            valid_in = right_i.valid;
            value_in = right_i.value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign self_o.valid = valid_ff;
   assign self_o.le    = le_self;
   assign self_o.value = value_ff;

endmodule : kssh_cell
`default_nettype wire
